// ===== hw/rtl/mrc_pkg.sv =====
// mrc_pkg: shared constants, opcodes and beat payload types for the
// multinomial resample counter. No dependencies.
package mrc_pkg;

    localparam int MAX_BINS   = 1024;
    localparam int COUNT_BITS = 16;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 33;
    localparam int BIN_W    = 10;
    localparam int COUNT_W  = 16;
    localparam int ACTIVE_W = 11;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;

    localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DRAW = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
        logic [BIN_W-1:0]    bin_index;
    } req_t;

    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic [COUNT_W-1:0] count;
        logic               miss;
    } rsp_t;

endpackage

// ===== hw/rtl/mrc_ifs.sv =====
// mrc_ifs: valid/ready channel interfaces for request and response beats.
// Depends on mrc_pkg.
interface mrc_req_if;
    logic          valid;
    logic          ready;
    mrc_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mrc_rsp_if;
    logic          valid;
    logic          ready;
    mrc_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mrc_ram.sv =====
// mrc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/multinomial_resample_counter_top.sv =====
// per request: load and unused opcodes go from idle to done, read through read-clear to done;
// draw runs k search steps, then update and done on a hit, done on a miss, or done at once
// with no active bins; k at most floor(log2(n)) + 1, so 11 for 1024 bins; one weight ram read
// per step, then count update. throughput: one request at a time; the next beat can be taken
// once the result is registered, while a stalled result keeps the block busy.
// reset: async, active low; counts cleared in a pass over all bins before the first beat; active 1024.
module multinomial_resample_counter_top #(
    parameter int MAX_BINS   = mrc_pkg::MAX_BINS,
    parameter int COUNT_BITS = mrc_pkg::COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mrc_pkg::ACTIVE_W-1:0]  cfg_wdata,
    mrc_req_if.sink                       req,
    mrc_rsp_if.source                     rsp
);

    localparam int IDX_W  = $clog2(MAX_BINS);
    localparam int N_W    = $clog2(MAX_BINS + 1);
    localparam int CMP_W  = (N_W > mrc_pkg::ACTIVE_W) ? N_W : mrc_pkg::ACTIVE_W;
    localparam int CX_W   = (COUNT_BITS > mrc_pkg::COUNT_W) ? COUNT_BITS : mrc_pkg::COUNT_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_RDCLR  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [mrc_pkg::ACTIVE_W-1:0]    active_reg;
    logic [IDX_W-1:0]                clr_reg;
    logic                            out_valid_reg;
    mrc_pkg::rsp_t                   out_data_reg;

    logic [N_W-1:0]                  lo_reg, hi_reg;
    logic [IDX_W-1:0]                mid_reg;
    logic [mrc_pkg::VALUE_W-1:0]     value_reg;
    logic [mrc_pkg::BIN_W-1:0]       res_bin_reg;
    logic [mrc_pkg::COUNT_W-1:0]     res_count_reg;
    logic                            res_miss_reg;

    logic                            accept;
    logic                            out_free;
    logic [CMP_W-1:0]                active_cmp;
    logic [N_W-1:0]                  n_eff;
    logic [CMP_W-1:0]                idx_cmp;
    logic                            idx_ok;
    logic [IDX_W-1:0]                idx_addr;

    logic                            w_we;
    logic [mrc_pkg::VALUE_W-1:0]     w_rdata;
    logic                            gt;
    logic [N_W-1:0]                  lo_step, hi_step;
    logic [N_W-1:0]                  s_lo, s_hi;
    logic [N_W:0]                    s_sum;
    logic [N_W-1:0]                  s_mid;
    logic [CMP_W-1:0]                hit_ext;

    logic                            c_we;
    logic [IDX_W-1:0]                c_waddr, c_raddr;
    logic [COUNT_BITS-1:0]           c_wdata, c_rdata, c_inc;
    logic [CX_W-1:0]                 c_ext;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // active count clamped to the table size
    assign active_cmp = CMP_W'(active_reg);
    assign n_eff = (active_cmp > CMP_W'(MAX_BINS)) ? N_W'(MAX_BINS) : active_cmp[N_W-1:0];

    assign idx_cmp  = CMP_W'(req.data.bin_index);
    assign idx_ok   = idx_cmp < CMP_W'(MAX_BINS);
    assign idx_addr = idx_cmp[IDX_W-1:0];

    // shared search step: compare last read weight, narrow the range, form next midpoint
    assign gt      = w_rdata > value_reg;
    assign lo_step = gt ? lo_reg : (N_W'(mid_reg) + N_W'(1));
    assign hi_step = gt ? N_W'(mid_reg) : hi_reg;
    assign s_lo    = (state_reg == ST_SEARCH) ? lo_step : '0;
    assign s_hi    = (state_reg == ST_SEARCH) ? hi_step : n_eff;
    assign s_sum   = {1'b0, s_lo} + {1'b0, s_hi};
    assign s_mid   = s_sum[N_W:1];
    assign hit_ext = CMP_W'(lo_step);

    assign w_we = accept && (req.data.opcode == mrc_pkg::OP_LOAD) && idx_ok;

    mrc_ram #(
        .WIDTH (mrc_pkg::VALUE_W),
        .DEPTH (MAX_BINS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (idx_addr),
        .wdata (req.data.value),
        .raddr (s_mid[IDX_W-1:0]),
        .rdata (w_rdata)
    );

    assign c_inc   = (c_rdata == '1) ? c_rdata : (c_rdata + COUNT_BITS'(1));
    assign c_ext   = CX_W'(c_rdata);
    assign c_we    = (state_reg == ST_CLEAR) || (state_reg == ST_UPDATE)
                     || (state_reg == ST_RDCLR);
    assign c_waddr = (state_reg == ST_CLEAR) ? clr_reg : mid_reg;
    assign c_wdata = (state_reg == ST_UPDATE) ? c_inc : '0;
    assign c_raddr = (state_reg == ST_IDLE) ? idx_addr : lo_step[IDX_W-1:0];

    mrc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_BINS)
    ) u_count_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(MAX_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.data.opcode == mrc_pkg::OP_DRAW && n_eff != '0)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else if (req.data.opcode == mrc_pkg::OP_READ && idx_ok)
                    begin
                        state_next = ST_RDCLR;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (lo_step >= hi_step)
                begin
                    state_next = (lo_step == n_eff) ? ST_DONE : ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_DONE;
            ST_RDCLR:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            active_reg    <= mrc_pkg::ACTIVE_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_reg     <= req.data.value;
                    lo_reg        <= s_lo;
                    hi_reg        <= s_hi;
                    mid_reg       <= (req.data.opcode == mrc_pkg::OP_DRAW) ?
                                     s_mid[IDX_W-1:0] : idx_addr;
                    res_count_reg <= '0;
                    // a draw with no active bins misses at once
                    res_bin_reg   <= (req.data.opcode == mrc_pkg::OP_DRAW) ?
                                     '0 : req.data.bin_index;
                    res_miss_reg  <= (req.data.opcode == mrc_pkg::OP_DRAW) && (n_eff == '0);
                end
            end
            ST_SEARCH:
            begin
                lo_reg <= lo_step;
                hi_reg <= hi_step;
                if (lo_step < hi_step)
                begin
                    mid_reg <= s_mid[IDX_W-1:0];
                end
                else
                begin
                    mid_reg <= lo_step[IDX_W-1:0];
                    if (lo_step == n_eff)
                    begin
                        res_miss_reg <= 1'b1;
                        res_bin_reg  <= '0;
                    end
                    else
                    begin
                        res_bin_reg <= hit_ext[mrc_pkg::BIN_W-1:0];
                    end
                end
            end
            ST_RDCLR:
            begin
                res_count_reg <= c_ext[mrc_pkg::COUNT_W-1:0];
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg.bin   <= res_bin_reg;
                    out_data_reg.count <= res_count_reg;
                    out_data_reg.miss  <= res_miss_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // the search range never collapses while a weight read is pending
    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> lo_reg < hi_reg)
        else $error("search entered with empty range");

    // counts are only written by the clear pass, an update or a read-clear
    a_no_count_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH || state_reg == ST_IDLE || state_reg == ST_DONE) |-> !c_we)
        else $error("count ram written outside its slots");

    // one request at a time: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken while previous one in flight");

    // a miss always reports bin zero and no count
    a_miss_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.miss |-> out_data_reg.bin == '0 && out_data_reg.count == '0)
        else $error("miss result carries a bin or count");

endmodule
